// ----- hw/rtl/month_grid_generator_defines.svh -----
// Assertion macros shared by the month grid checker.
`ifndef MONTH_GRID_GENERATOR_DEFINES_SVH
`define MONTH_GRID_GENERATOR_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define MGG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while in reset.
`define MGG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/mgg_pkg.sv -----
// Types, constants and helper functions for the month grid generator.
`timescale 1ns / 1ps

package mgg_pkg;

	localparam int YEAR_W  = 14;
	localparam int SYEAR_W = 15;

	localparam logic [2:0] KIND_PREV     = 3'd0;
	localparam logic [2:0] KIND_WEEKDAY  = 3'd1;
	localparam logic [2:0] KIND_WEEKEND  = 3'd2;
	localparam logic [2:0] KIND_SELECTED = 3'd3;
	localparam logic [2:0] KIND_NEXT     = 3'd4;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	// floor(x / 100) = (x * 5243) >> 19 for x below 2^15
	localparam logic [12:0] RECIP100 = 13'd5243;
	// floor(x / 7) = (x * 2341) >> 14 for x below 2^11
	localparam logic [11:0] RECIP7   = 12'd2341;

	localparam logic [SYEAR_W-1:0] YEAR_SHIFT = 15'd400;

	typedef struct packed {
		logic [2:0] first;
		logic [4:0] mlen;
		logic [4:0] plen;
		logic [4:0] day;
		logic [2:0] wd;
	} mgg_item_t;

	function automatic logic [2:0] mod7(input logic [10:0] s);
		logic [22:0] p;
		logic [10:0] q;
		logic [10:0] r;
		p = 23'(s) * 23'(RECIP7);
		q = {2'b00, p[22:14]};
		r = s - 11'(q * 11'd7);
		return r[2:0];
	endfunction

	// floor(13 * (cm + 1) / 5) for the shifted month 3..14
	function automatic logic [5:0] zeller_month_term(input logic [3:0] cm);
		logic [5:0] t;
		case (cm)
			4'd3:    t = 6'd10;
			4'd4:    t = 6'd13;
			4'd5:    t = 6'd15;
			4'd6:    t = 6'd18;
			4'd7:    t = 6'd20;
			4'd8:    t = 6'd23;
			4'd9:    t = 6'd26;
			4'd10:   t = 6'd28;
			4'd11:   t = 6'd31;
			4'd12:   t = 6'd33;
			4'd13:   t = 6'd36;
			4'd14:   t = 6'd39;
			default: t = 6'd0;
		endcase
		return t;
	endfunction

	function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		case (m)
			4'd2:                   d = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			default:                d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

// ----- hw/rtl/mgg_front.sv -----
// Front pipeline: weekday of day 1 and of the selected day, month lengths.
`timescale 1ns / 1ps

module mgg_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [13:0]               sel_year,
	input  logic [3:0]                sel_month,
	input  logic [4:0]                sel_day,
	output logic                      item_valid,
	input  logic                      item_ready,
	output mgg_pkg::mgg_item_t        item
);
	import mgg_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	// stage 1: clamp month, shift year, Zeller month/year fold
	logic [SYEAR_W-1:0] y_s1, cy_s1;
	logic [3:0]         mon_s1, cm_s1;
	logic [4:0]         day_s1;
	// stage 2: reciprocal products for the divisions by 100
	logic [27:0]        pj_s2, py_s2;
	logic [SYEAR_W-1:0] y_s2, cy_s2;
	logic [3:0]         mon_s2, cm_s2;
	logic [4:0]         day_s2;
	// stage 3: century and year-of-century, leap flag
	logic [7:0]         j_s3;
	logic [6:0]         k_s3;
	logic               leap_s3;
	logic [3:0]         mon_s3, cm_s3;
	logic [4:0]         day_s3;
	// stage 4: Zeller sum and month lengths
	logic [10:0]        sum_s4;
	logic [4:0]         mlen_s4, plen_s4, day_s4;
	// stage 5: weekdays
	mgg_item_t          item_s5;

	logic [3:0]         mon_c;
	logic [SYEAR_W-1:0] y_c;
	logic [7:0]         j_c, qy_c;
	logic [SYEAR_W-1:0] k_c, ry_c;
	logic               leap_c;
	logic [10:0]        sum_c, wsum_c;

	assign en_s5 = !v_s5 || item_ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign in_stall   = !en_s1;
	assign item_valid = v_s5;
	assign item       = item_s5;

	always_comb begin
		if (sel_month < MONTH_JAN) begin
			mon_c = MONTH_JAN;
		end else if (sel_month > MONTH_DEC) begin
			mon_c = MONTH_DEC;
		end else begin
			mon_c = sel_month;
		end
		y_c = SYEAR_W'(sel_year) + YEAR_SHIFT;
	end

	always_comb begin
		j_c    = pj_s2[26:19];
		qy_c   = py_s2[26:19];
		k_c    = cy_s2 - SYEAR_W'(SYEAR_W'(j_c) * SYEAR_W'(100));
		ry_c   = y_s2 - SYEAR_W'(SYEAR_W'(qy_c) * SYEAR_W'(100));
		leap_c = (y_s2[1:0] == 2'b00) && ((ry_c != '0) || (qy_c[1:0] == 2'b00));
	end

	always_comb begin
		sum_c = 11'(zeller_month_term(cm_s3)) + 11'(k_s3) + 11'(k_s3[6:2])
			+ 11'(j_s3[7:2]) + 11'(j_s3) + 11'({j_s3, 2'b00});
		wsum_c = sum_s4 + 11'(day_s4) + 11'd6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			y_s1   <= y_c;
			mon_s1 <= mon_c;
			day_s1 <= sel_day;
			// January and February count as months 13 and 14 of the year before
			if (mon_c < 4'd3) begin
				cm_s1 <= mon_c + 4'd12;
				cy_s1 <= y_c - SYEAR_W'(1);
			end else begin
				cm_s1 <= mon_c;
				cy_s1 <= y_c;
			end
		end
		if (en_s2) begin
			pj_s2  <= 28'(cy_s1) * 28'(RECIP100);
			py_s2  <= 28'(y_s1) * 28'(RECIP100);
			y_s2   <= y_s1;
			cy_s2  <= cy_s1;
			mon_s2 <= mon_s1;
			cm_s2  <= cm_s1;
			day_s2 <= day_s1;
		end
		if (en_s3) begin
			j_s3    <= j_c;
			k_s3    <= k_c[6:0];
			leap_s3 <= leap_c;
			mon_s3  <= mon_s2;
			cm_s3   <= cm_s2;
			day_s3  <= day_s2;
		end
		if (en_s4) begin
			sum_s4  <= sum_c;
			mlen_s4 <= month_length(mon_s3, leap_s3);
			// December before January is always 31 days
			plen_s4 <= (mon_s3 == MONTH_JAN) ? 5'd31 : month_length(mon_s3 - 4'd1, leap_s3);
			day_s4  <= day_s3;
		end
		if (en_s5) begin
			item_s5.first <= mod7(sum_s4);
			item_s5.wd    <= mod7(wsum_c);
			item_s5.mlen  <= mlen_s4;
			item_s5.plen  <= plen_s4;
			item_s5.day   <= day_s4;
		end
	end

endmodule

// ----- hw/rtl/mgg_cells.sv -----
// Cell sequencer: walks the grid of one date and registers one cell per cycle while the output is not stalled.
`timescale 1ns / 1ps

module mgg_cells #(
	parameter int GRID_ROWS = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  mgg_pkg::mgg_item_t item,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         cell_row,
	output logic [2:0]         cell_col,
	output logic [4:0]         day_number,
	output logic [2:0]         cell_kind,
	output logic [2:0]         date_weekday,
	output logic               last_cell
);
	import mgg_pkg::*;

	localparam int CUR_W = $clog2(7 * GRID_ROWS + 1) + 1;

	logic                    busy_q;
	logic signed [CUR_W-1:0] cur_q;
	logic [3:0]              row_q;
	logic [2:0]              col_q;
	mgg_item_t               item_q;

	logic                    out_v_q;
	logic [3:0]              row_out_q;
	logic [2:0]              col_out_q;
	logic [4:0]              day_out_q;
	logic [2:0]              kind_out_q;
	logic [2:0]              wd_out_q;
	logic                    last_out_q;

	logic                    emit, load, at_last;
	logic signed [CUR_W-1:0] mlen_x, nxt;
	logic [4:0]              shown;
	logic [2:0]              kind;

	assign at_last    = (row_q == 4'(GRID_ROWS - 1)) && (col_q == 3'd6);
	assign emit       = busy_q && (!out_v_q || !out_stall);
	assign item_ready = !busy_q || (emit && at_last);
	assign load       = item_valid && item_ready;

	assign mlen_x = $signed(CUR_W'(item_q.mlen));
	assign nxt    = cur_q - mlen_x;

	always_comb begin
		if (cur_q < $signed(CUR_W'(1))) begin
			// tail of the previous month; cursor is between -5 and 0
			shown = item_q.plen + cur_q[4:0];
			kind  = KIND_PREV;
		end else if (cur_q > mlen_x) begin
			// next month; saturating at 31 is only reachable with more than six rows
			shown = (nxt > $signed(CUR_W'(31))) ? 5'd31 : nxt[4:0];
			kind  = KIND_NEXT;
		end else begin
			shown = cur_q[4:0];
			if (cur_q[4:0] == item_q.day) begin
				kind = KIND_SELECTED;
			end else if (col_q == 3'd0 || col_q == 3'd6) begin
				kind = KIND_WEEKEND;
			end else begin
				kind = KIND_WEEKDAY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
			end else if (emit && at_last) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item;
			cur_q  <= $signed(CUR_W'(1)) - $signed(CUR_W'(item.first));
			row_q  <= 4'd0;
			col_q  <= 3'd0;
		end else if (emit) begin
			cur_q <= cur_q + $signed(CUR_W'(1));
			if (col_q == 3'd6) begin
				col_q <= 3'd0;
				row_q <= row_q + 4'd1;
			end else begin
				col_q <= col_q + 3'd1;
			end
		end
		if (emit) begin
			row_out_q  <= row_q;
			col_out_q  <= col_q;
			day_out_q  <= shown;
			kind_out_q <= kind;
			wd_out_q   <= item_q.wd;
			last_out_q <= at_last;
		end
	end

	assign out_valid    = out_v_q;
	assign cell_row     = row_out_q;
	assign cell_col     = col_out_q;
	assign day_number   = day_out_q;
	assign cell_kind    = kind_out_q;
	assign date_weekday = wd_out_q;
	assign last_cell    = last_out_q;

endmodule

// ----- hw/rtl/month_grid_generator.sv -----
// A date passes the five front stages, then the sequencer's item register and its cell register.
// Throughput: one cell per cycle while out_stall is low, GRID_ROWS*7 cells per date, set by the cell sequencer.
// A five-stage front pipeline works out weekdays and month lengths for the next dates
// while the sequencer still emits the current grid.
// Reset (arst_n low) clears all valid bits and the sequencer at once; no clearing pass.
`timescale 1ns / 1ps

module month_grid_generator #(
	parameter int GRID_ROWS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [13:0] sel_year,
	input  logic [3:0]  sel_month,
	input  logic [4:0]  sel_day,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  cell_row,
	output logic [2:0]  cell_col,
	output logic [4:0]  day_number,
	output logic [2:0]  cell_kind,
	output logic [2:0]  date_weekday,
	output logic        last_cell
);
	import mgg_pkg::*;

	logic      item_valid, item_ready;
	mgg_item_t item;

	mgg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sel_year   (sel_year),
		.sel_month  (sel_month),
		.sel_day    (sel_day),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	mgg_cells #(
		.GRID_ROWS (GRID_ROWS)
	) u_cells (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cell_row     (cell_row),
		.cell_col     (cell_col),
		.day_number   (day_number),
		.cell_kind    (cell_kind),
		.date_weekday (date_weekday),
		.last_cell    (last_cell)
	);

endmodule

// ----- hw/rtl/mgg_checker.sv -----
// Port-level checker for the month grid generator, bound to the top level.
`timescale 1ns / 1ps
`include "month_grid_generator_defines.svh"

module mgg_checker #(
	parameter int GRID_ROWS = 6
) (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [3:0] cell_row,
	input logic [2:0] cell_col,
	input logic [4:0] day_number,
	input logic [2:0] cell_kind,
	input logic [2:0] date_weekday,
	input logic       last_cell
);
	import mgg_pkg::*;

	`MGG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(cell_col) && $stable(day_number) && $stable(cell_kind),
		"stalled cell changed")

	`MGG_ASSERT_NOW(a_last_pos, clk, arst_n, out_valid,
		last_cell == ((cell_row == 4'(GRID_ROWS - 1)) && (cell_col == 3'd6)),
		"last cell flag off the final grid position")

	`MGG_ASSERT_NEXT(a_grid_walk, clk, arst_n, out_valid && !out_stall && !last_cell,
		out_valid && (date_weekday == $past(date_weekday))
			&& (cell_col == (($past(cell_col) == 3'd6) ? 3'd0 : $past(cell_col) + 3'd1)),
		"grid walk broke between cells of one date")

	`MGG_ASSERT_NOW(a_prev_top, clk, arst_n, out_valid && (cell_kind == KIND_PREV),
		cell_row == 4'd0,
		"previous month cell below the top row")

endmodule

bind month_grid_generator mgg_checker #(.GRID_ROWS(GRID_ROWS)) u_mgg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.cell_row     (cell_row),
	.cell_col     (cell_col),
	.day_number   (day_number),
	.cell_kind    (cell_kind),
	.date_weekday (date_weekday),
	.last_cell    (last_cell)
);

// ----- dv/month_grid_checker.sv -----
// Checker for the month grid generator: predicts each date's grid and compares the cells.
`timescale 1ns / 1ps

module month_grid_checker #(
	parameter int GRID_ROWS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [13:0] sel_year,
	input  logic [3:0]  sel_month,
	input  logic [4:0]  sel_day,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [3:0]  cell_row,
	input  logic [2:0]  cell_col,
	input  logic [4:0]  day_number,
	input  logic [2:0]  cell_kind,
	input  logic [2:0]  date_weekday,
	input  logic        last_cell,
	output int          errors,
	output int          cells_due,
	output int          cells_seen
);
	import mgg_pkg::*;

	localparam int SATURDAY  = 6;
	localparam int GRID_SIZE = GRID_ROWS * 7;

	typedef struct packed {
		logic [3:0] row;
		logic [2:0] col;
		logic [4:0] day;
		logic [2:0] kind;
		logic [2:0] wd;
		logic       last;
	} grid_cell_t;

	grid_cell_t grid_cells_due[$];
	int         err_cnt  = 0;
	int         due_cnt  = 0;
	int         seen_cnt = 0;

	assign errors     = err_cnt;
	assign cells_due  = due_cnt;
	assign cells_seen = seen_cnt;

	// y is the year shifted by 400, m is 1..12
	function automatic int days_in(int y, int m);
		int lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		if (m == MONTH_FEB && ((y % 400 == 0) || (y % 100 != 0 && y % 4 == 0)))
			return 29;
		return lens[m - 1];
	endfunction

	// Zeller's congruence, 0 is Sunday
	function automatic int weekday_of(int y, int m, int d);
		int cy, cm, j, k, h;
		cy = y;
		cm = m;
		if (cm < 3) begin
			cm += 12;
			cy -= 1;
		end
		j = cy / 100;
		k = cy % 100;
		h = (d + (13 * (cm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
		return (h + 6) % 7;
	endfunction

	task automatic build_month_grid(logic [13:0] y_in, logic [3:0] m_in, logic [4:0] d_in);
		int         y, m, d, mlen, plen, wd, cursor, shown, n, r, col;
		grid_cell_t entry;
		// the calendar repeats every 400 years, which keeps year 0 well defined
		y = int'(y_in) + 400;
		m = int'(m_in);
		d = int'(d_in);
		if (m < MONTH_JAN)
			m = MONTH_JAN;
		if (m > MONTH_DEC)
			m = MONTH_DEC;
		mlen   = days_in(y, m);
		plen   = (m == MONTH_JAN) ? days_in(y - 1, MONTH_DEC) : days_in(y, m - 1);
		wd     = weekday_of(y, m, d);
		cursor = 1 - weekday_of(y, m, 1);
		n      = 0;
		for (r = 0; r < GRID_ROWS; r++) begin
			for (col = 0; col < 7; col++) begin
				if (cursor < 1) begin
					shown      = plen + cursor;
					entry.kind = KIND_PREV;
				end else if (cursor > mlen) begin
					// saturate past day 31 on tall grids
					shown      = (cursor - mlen > 31) ? 31 : cursor - mlen;
					entry.kind = KIND_NEXT;
				end else begin
					shown = cursor;
					if (shown == d)
						entry.kind = KIND_SELECTED;
					else if (col == 0 || col == SATURDAY)
						entry.kind = KIND_WEEKEND;
					else
						entry.kind = KIND_WEEKDAY;
				end
				entry.row  = 4'(r);
				entry.col  = 3'(col);
				entry.day  = 5'(shown);
				entry.wd   = 3'(wd);
				entry.last = (n == GRID_SIZE - 1);
				grid_cells_due.push_back(entry);
				n++;
				cursor++;
			end
		end
	endtask

	always @(posedge clk) begin
		grid_cell_t got, want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				build_month_grid(sel_year, sel_month, sel_day);
			if (out_valid && !out_stall) begin
				got = '{cell_row, cell_col, day_number, cell_kind, date_weekday, last_cell};
				seen_cnt++;
				if (grid_cells_due.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected cell row %0d col %0d day %0d kind %0d wd %0d last %0d",
						$time, got.row, got.col, got.day, got.kind, got.wd, got.last);
				end else begin
					want = grid_cells_due.pop_front();
					if (got !== want) begin
						err_cnt++;
						$display("%0t: cell mismatch expected row %0d col %0d day %0d kind %0d wd %0d last %0d",
							$time, want.row, want.col, want.day, want.kind, want.wd, want.last);
						$display("%0t:                actual row %0d col %0d day %0d kind %0d wd %0d last %0d",
							$time, got.row, got.col, got.day, got.kind, got.wd, got.last);
					end
				end
			end
			due_cnt = grid_cells_due.size();
		end
	end

endmodule

// ----- dv/tb_month_grid_generator.sv -----
// Testbench top for the month grid generator: date stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_month_grid_generator;

	localparam int GRID_ROWS  = 6;
	localparam int RAND_DATES = 128;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [13:0] sel_year;
	logic [3:0]  sel_month;
	logic [4:0]  sel_day;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  cell_row;
	logic [2:0]  cell_col;
	logic [4:0]  day_number;
	logic [2:0]  cell_kind;
	logic [2:0]  date_weekday;
	logic        last_cell;

	int errors;
	int cells_due;
	int cells_seen;
	int idle_pct  = 0;
	int stall_pct = 0;
	int dates_sent = 0;

	month_grid_generator #(
		.GRID_ROWS(GRID_ROWS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sel_year    (sel_year),
		.sel_month   (sel_month),
		.sel_day     (sel_day),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cell_row    (cell_row),
		.cell_col    (cell_col),
		.day_number  (day_number),
		.cell_kind   (cell_kind),
		.date_weekday(date_weekday),
		.last_cell   (last_cell)
	);

	month_grid_checker #(
		.GRID_ROWS(GRID_ROWS)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sel_year    (sel_year),
		.sel_month   (sel_month),
		.sel_day     (sel_day),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cell_row    (cell_row),
		.cell_col    (cell_col),
		.day_number  (day_number),
		.cell_kind   (cell_kind),
		.date_weekday(date_weekday),
		.last_cell   (last_cell),
		.errors      (errors),
		.cells_due   (cells_due),
		.cells_seen  (cells_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_month_grid_generator: errors");
		$finish;
	end

	// receiver back-pressure
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_date(logic [13:0] y, logic [3:0] m, logic [4:0] d);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		sel_year  <= y;
		sel_month <= m;
		sel_day   <= d;
		do
			@(posedge clk);
		while (in_stall);
		dates_sent++;
		@(negedge clk);
	endtask

	// Drop the request and hold until every predicted cell has been seen.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (cells_due != 0)
			@(negedge clk);
	endtask

	task automatic send_random_date();
		logic [13:0] y;
		logic [3:0]  m;
		logic [4:0]  d;
		if ($urandom_range(99) < 80) begin
			y = 14'($urandom_range(9999, 1));
			m = 4'($urandom_range(12, 1));
			d = 5'($urandom_range(31, 1));
		end else begin
			y = 14'($urandom);
			m = 4'($urandom);
			d = 5'($urandom);
		end
		send_date(y, m, d);
	endtask

	initial begin
		int idle_mix[4]  = '{0, 61, 0, 31};
		int stall_mix[4] = '{0, 0, 61, 31};
		int phase, i;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		sel_year  = 14'd2000;
		sel_month = 4'd1;
		sel_day   = 5'd1;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// year and field extremes
		send_date(14'd1, 4'd1, 5'd1);
		send_date(14'd9999, 4'd12, 5'd31);
		send_date(14'd0, 4'd1, 5'd15);
		send_date(14'd16383, 4'd7, 5'd4);
		// out-of-range months saturate
		send_date(14'd2021, 4'd0, 5'd10);
		send_date(14'd2021, 4'd13, 5'd25);
		send_date(14'd2021, 4'd15, 5'd31);
		// leap rules around February
		send_date(14'd2000, 4'd2, 5'd29);
		send_date(14'd1900, 4'd2, 5'd28);
		send_date(14'd2024, 4'd2, 5'd29);
		send_date(14'd2023, 4'd2, 5'd29);
		send_date(14'd2024, 4'd3, 5'd1);
		send_date(14'd2100, 4'd3, 5'd2);
		// January takes December of the prior year
		send_date(14'd2001, 4'd1, 5'd31);
		send_date(14'd2000, 4'd1, 5'd6);
		// day zero or past month length marks nothing
		send_date(14'd2022, 4'd4, 5'd31);
		send_date(14'd2022, 4'd6, 5'd0);
		send_date(14'd2015, 4'd2, 5'd30);
		// first day on Sunday and on Saturday
		send_date(14'd2015, 4'd2, 5'd1);
		send_date(14'd2020, 4'd8, 5'd31);
		send_date(14'd2020, 4'd8, 5'd1);
		send_date(14'd1752, 4'd9, 5'd14);
		wait_drained();

		for (phase = 0; phase < 4; phase++) begin
			idle_pct  = idle_mix[phase];
			stall_pct = stall_mix[phase];
			for (i = 0; i < RAND_DATES / 4; i++)
				send_random_date();
			// hold the sender until every grid is out
			if (phase == 1)
				wait_drained();
		end

		wait_drained();
		repeat (20) @(negedge clk);
		$display("Sent %0d dates and checked %0d cells under four idle and stall mixes",
			dates_sent, cells_seen);
		$display("Covered year, month and day extremes, leap rules and unmarked days");
		if (errors == 0 && cells_due == 0)
			$display("tb_month_grid_generator: clean");
		else
			$display("tb_month_grid_generator: errors");
		$finish;
	end

endmodule
